// ===== rtl/core/sbfd_pkg.sv =====
`timescale 1ns / 1ps

package sbfd_pkg;

    localparam int FRAME_LEN  = 25;
    localparam int NUM_CELLS  = FRAME_LEN - 2;  // frame bytes 1..23 behind the sync byte
    localparam int NUM_CHANS  = 10;
    localparam int CHAN_W     = 11;
    localparam int CNT_W      = 5;
    localparam int FLAGS_POS  = 23;
    localparam int CHAN_BYTES = 14;             // bytes 1..14 carry the first ten channels

    typedef logic [7:0]        byte_t;
    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [CNT_W-1:0]  count_t;

    localparam byte_t  SYNC_BYTE = 8'h0F;
    localparam byte_t  ZERO_BYTE = 8'h00;
    localparam count_t CNT_IDLE  = 5'd0;
    localparam count_t CNT_LAST  = 5'(FRAME_LEN - 1);

endpackage

// ===== rtl/core/sbfd_if.sv =====
`timescale 1ns / 1ps

interface sbfd_byte_if;
    import sbfd_pkg::*;
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfd_chan_if;
    import sbfd_pkg::*;
    logic  valid;
    logic  ready;
    chan_t chan1;
    chan_t chan2;
    chan_t chan3;
    chan_t chan4;
    chan_t chan5;
    chan_t chan6;
    chan_t chan7;
    chan_t chan8;
    chan_t chan9;
    chan_t chan10;
    logic  fault;

    modport source (output valid, output chan1, output chan2, output chan3, output chan4,
                    output chan5, output chan6, output chan7, output chan8, output chan9,
                    output chan10, output fault, input ready);
    modport sink   (input valid, input chan1, input chan2, input chan3, input chan4,
                    input chan5, input chan6, input chan7, input chan8, input chan9,
                    input chan10, input fault, output ready);
endinterface

// ===== rtl/core/sbfd_cell.sv =====
`timescale 1ns / 1ps

// One byte stage of the frame shift line.
module sbfd_cell
    import sbfd_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  byte_t d,
    output byte_t q
);

    byte_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// ===== rtl/core/sbus_frame_channel_decoder.sv =====
`timescale 1ns / 1ps

// SBUS frame decoder. Takes one received serial byte per beat and hunts for
// the sync byte 0x0F; after it, 24 more bytes make up the frame (the end byte
// is not checked, and a 0x0F inside a frame is plain data). On the beat that
// carries the 25th byte, one result beat is queued: channels 1..10 (11 bits
// each, little-endian packed from frame byte 1) and fault, set when the
// flags byte (byte 23) is nonzero. Channels are always sent; ignore them
// when fault is set. One byte is taken every cycle unless intake is stalled;
// the result shows on the channels port the cycle after the last frame byte
// is taken. The result sits in a single output register: while it waits unread,
// byte intake stops, and it resumes in the same cycle the result is taken.
module sbus_frame_channel_decoder
    import sbfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sbfd_byte_if.sink   bytes,
    sbfd_chan_if.source channels
);

    // handshake
    logic   take;
    logic   emit;
    logic   out_valid_reg;
    logic   out_valid_next;
    count_t byte_count_reg;
    count_t byte_count_next;

    assign bytes.ready = !out_valid_reg || channels.ready;
    assign take        = bytes.valid && bytes.ready;

    // frame counter: 0 means hunting for sync
    always_comb
    begin
        byte_count_next = byte_count_reg;
        emit            = 1'b0;
        if (take)
        begin
            case (byte_count_reg)
                CNT_IDLE:
                begin
                    byte_count_next = (bytes.rx_byte == SYNC_BYTE) ? count_t'(1) : CNT_IDLE;
                end
                CNT_LAST:
                begin
                    byte_count_next = CNT_IDLE;
                    emit            = 1'b1;
                end
                default:
                begin
                    // out-of-range counts fall back to hunting
                    if (byte_count_reg > CNT_LAST)
                    begin
                        byte_count_next = (bytes.rx_byte == SYNC_BYTE) ? count_t'(1) : CNT_IDLE;
                    end
                    else
                    begin
                        byte_count_next = byte_count_reg + count_t'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= CNT_IDLE;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
        end
    end

    // shift line: cell 0 holds the newest byte. With the last byte on the
    // input, cell k holds frame byte 23-k.
    byte_t cell_q [NUM_CELLS];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                sbfd_cell u_cell (
                    .clk   (clk),
                    .shift (take),
                    .d     (bytes.rx_byte),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_body
                sbfd_cell u_cell (
                    .clk   (clk),
                    .shift (take),
                    .d     (cell_q[gi-1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    // bit stream of frame bytes 1..14, byte 1 at the bottom
    logic [8*CHAN_BYTES-1:0] stream;
    chan_t                   chan_dec [NUM_CHANS];

    generate
        for (gi = 0; gi < CHAN_BYTES; gi++)
        begin : g_stream
            assign stream[8*gi +: 8] = cell_q[FLAGS_POS - 1 - gi];
        end
        for (gi = 0; gi < NUM_CHANS; gi++)
        begin : g_chan
            assign chan_dec[gi] = stream[CHAN_W*gi +: CHAN_W];
        end
    endgenerate

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (channels.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    chan_t chan_reg [NUM_CHANS];
    logic  fault_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            chan_reg  <= chan_dec;
            fault_reg <= (cell_q[0] != ZERO_BYTE);
        end
    end

    assign channels.valid  = out_valid_reg;
    assign channels.chan1  = chan_reg[0];
    assign channels.chan2  = chan_reg[1];
    assign channels.chan3  = chan_reg[2];
    assign channels.chan4  = chan_reg[3];
    assign channels.chan5  = chan_reg[4];
    assign channels.chan6  = chan_reg[5];
    assign channels.chan7  = chan_reg[6];
    assign channels.chan8  = chan_reg[7];
    assign channels.chan9  = chan_reg[8];
    assign channels.chan10 = chan_reg[9];
    assign channels.fault  = fault_reg;

endmodule

// ===== rtl/core/sbfd_checker.sv =====
`timescale 1ns / 1ps

module sbfd_checker
    import sbfd_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input chan_t out_chan1,
    input logic  out_fault
);

    // result beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_chan1) && $stable(out_fault))
        else $error("stalled result beat changed");

    // a result only follows a byte beat
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result beat without a byte beat");

    // unread result stops intake, empty output never does
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("byte taken while result stalled");

    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("intake stopped with empty output");

endmodule

bind sbus_frame_channel_decoder sbfd_checker u_sbfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bytes.valid),
    .in_ready  (bytes.ready),
    .out_valid (channels.valid),
    .out_ready (channels.ready),
    .out_chan1 (channels.chan1),
    .out_fault (channels.fault)
);

// ===== sim/sbus_frame_channel_decoder_test.sv =====
`timescale 1ns / 1ps

// Testbench for sbus_frame_channel_decoder.
//
// Bytes go in on the byte channel, decoded frames come out on the channel
// bus. Every accepted byte is also fed to a local frame assembler that
// tracks the hunt/collect state. On each completed frame it packs the
// expected channels and fault into a queue. The result checker compares
// each accepted result beat with the head of that queue, field by field.
//
// Stimulus runs as a list of test tasks: hunting on junk, channel extremes,
// sync values inside a frame, a long hold on the result side while bytes
// keep coming, and then a random stream. The random stream is mostly
// well-formed frames with noise, stray syncs and cut-off frames mixed in.
// Both sides idle at random, except during one quiet stretch.
module sbus_frame_channel_decoder_test;
    import sbfd_pkg::*;

    typedef struct packed {
        chan_t [NUM_CHANS-1:0] chans;
        logic                  fault;
    } chan_frame_t;

    typedef byte_t frame_t [FRAME_LEN];

    localparam int IDLE_PCT      = 34;
    localparam int STALL_LIMIT   = 5000;   // far above the longest hold-off
    localparam int TAIL_CYCLES   = 20;     // result shows the cycle after the last byte is taken
    localparam int REPORT_MAX    = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_FRAMES = 30;

    logic clk;
    logic rst_n;

    sbfd_byte_if byte_bus ();
    sbfd_chan_if chan_bus ();

    sbus_frame_channel_decoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (byte_bus),
        .channels (chan_bus)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Handshake shorthand, sampled at the rising edge.
    logic byte_beat;
    logic chan_beat;
    assign byte_beat = byte_bus.valid && byte_bus.ready;
    assign chan_beat = chan_bus.valid && chan_bus.ready;

    // Knobs shared by the test tasks and the two sides.
    bit source_idle_en = 1'b1;
    bit sink_idle_en   = 1'b1;
    int hold_request   = 0;

    int errors      = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------
    // Frame assembler: mirrors the hunt/collect behavior of the block and
    // queues one expected result for every frame that completes.
    // ------------------------------------------------------------------
    byte_t       frame_buf [FRAME_LEN];
    count_t      frame_pos;
    chan_frame_t expected_frames [$];

    function automatic void assemble_byte(input byte_t b);
        int                          pos;
        logic [8*CHAN_BYTES-1:0]     bits;
        chan_frame_t                 f;
        pos = (int'(frame_pos) >= FRAME_LEN) ? 0 : int'(frame_pos);
        frame_buf[pos] = b;
        // Hunting: only a sync byte in slot 0 starts a frame.
        if (frame_buf[0] != SYNC_BYTE)
        begin
            frame_pos = CNT_IDLE;
            return;
        end
        pos++;
        if (pos < FRAME_LEN)
        begin
            frame_pos = count_t'(pos);
            return;
        end
        // Full frame: channels are a little-endian bit stream from byte 1.
        for (int i = 0; i < CHAN_BYTES; i++)
            bits[8*i +: 8] = frame_buf[i+1];
        for (int k = 0; k < NUM_CHANS; k++)
            f.chans[k] = bits[CHAN_W*k +: CHAN_W];
        f.fault = (frame_buf[FLAGS_POS] != ZERO_BYTE);
        expected_frames.push_back(f);
        frame_pos = CNT_IDLE;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and byte monitor.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        chan_frame_t got;
        chan_frame_t want;
        if (rst_n)
        begin
            if (chan_beat)
            begin
                got.chans[0] = chan_bus.chan1;
                got.chans[1] = chan_bus.chan2;
                got.chans[2] = chan_bus.chan3;
                got.chans[3] = chan_bus.chan4;
                got.chans[4] = chan_bus.chan5;
                got.chans[5] = chan_bus.chan6;
                got.chans[6] = chan_bus.chan7;
                got.chans[7] = chan_bus.chan8;
                got.chans[8] = chan_bus.chan9;
                got.chans[9] = chan_bus.chan10;
                got.fault    = chan_bus.fault;
                if (expected_frames.size() == 0)
                begin
                    if (errors < REPORT_MAX)
                        $display("%t: result beat with no frame pending", $realtime);
                    errors++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    for (int k = 0; k < NUM_CHANS; k++)
                    begin
                        if (got.chans[k] !== want.chans[k])
                        begin
                            if (errors < REPORT_MAX)
                                $display("%t: chan%0d expected %0d got %0d", $realtime,
                                         k + 1, want.chans[k], got.chans[k]);
                            errors++;
                        end
                    end
                    if (got.fault !== want.fault)
                    begin
                        if (errors < REPORT_MAX)
                            $display("%t: fault expected %0b got %0b", $realtime,
                                     want.fault, got.fault);
                        errors++;
                    end
                end
            end
            if (byte_beat)
                assemble_byte(byte_bus.rx_byte);
        end
    end

    // Cycles without any beat; the watchdog below trips on this.
    always @(posedge clk)
    begin
        if (byte_beat || chan_beat)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%t: no beat for %0d cycles", $realtime, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random ready, or a counted hold-off when a test asks.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        chan_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                chan_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (sink_idle_en)
                chan_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            else
                chan_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Byte side helpers. Called and returning at a rising edge.
    // ------------------------------------------------------------------
    task automatic send_byte(input byte_t b);
        while (source_idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            byte_bus.valid <= 1'b0;
            @(posedge clk);
        end
        byte_bus.valid   <= 1'b1;
        byte_bus.rx_byte <= b;
        do
            @(posedge clk);
        while (!byte_bus.ready);
    endtask

    task automatic send_frame(input frame_t fr);
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte(fr[i]);
    endtask

    function automatic frame_t random_frame(input bit with_fault);
        frame_t fr;
        fr[0] = SYNC_BYTE;
        for (int i = 1; i < FRAME_LEN; i++)
            fr[i] = byte_t'($urandom);
        fr[FLAGS_POS] = with_fault ? byte_t'($urandom_range(1, 255)) : ZERO_BYTE;
        return fr;
    endfunction

    // Stop offering bytes until every queued frame has been checked.
    // The extra edge lets the monitor log the final byte first.
    task automatic wait_drained();
        byte_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Junk while hunting: near-miss values around the sync byte, no results.
    task automatic test_hunting();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h0E);
        send_byte(8'h1F);
        send_byte(8'h8F);
    endtask

    // All-ones frame with flags 0xFF (fault, channels at max), then all zeros.
    task automatic test_channel_extremes();
        frame_t fr;
        fr[0] = SYNC_BYTE;
        for (int i = 1; i < FRAME_LEN; i++)
            fr[i] = 8'hFF;
        send_frame(fr);
        for (int i = 1; i < FRAME_LEN; i++)
            fr[i] = ZERO_BYTE;
        send_frame(fr);
    endtask

    // Sync value as data and as end byte; lowest nonzero flags. The next
    // frame must start cleanly right after.
    task automatic test_sync_inside_frame();
        frame_t fr;
        fr[0] = SYNC_BYTE;
        for (int i = 1; i < FRAME_LEN; i++)
            fr[i] = SYNC_BYTE;
        fr[FLAGS_POS] = 8'h01;
        send_frame(fr);
        for (int i = 1; i < FRAME_LEN; i++)
            fr[i] = (i % 2 != 0) ? 8'h55 : 8'hAA;
        fr[FLAGS_POS] = ZERO_BYTE;
        send_frame(fr);
    endtask

    // Result side holds off while frames keep coming: the output register
    // fills and byte intake must stall. Then the byte side pauses to drain.
    task automatic test_output_stall();
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < 3; n++)
            send_frame(random_frame(1'b0));
        wait_drained();
    endtask

    // Mostly good frames with noise between them; some stray syncs and
    // cut-off frames that shift the framing of what follows.
    task automatic test_random_traffic();
        byte_t b;
        int    frag_len;
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            // quiet stretch: no idling on either side
            source_idle_en = !(n >= 15 && n < 25);
            sink_idle_en   = source_idle_en;
            repeat ($urandom_range(0, 3))
            begin
                b = byte_t'($urandom);
                if (b == SYNC_BYTE && $urandom_range(0, 99) >= 15)
                    b = ~b;
                send_byte(b);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                frag_len = $urandom_range(1, FRAME_LEN - 2);
                send_byte(SYNC_BYTE);
                repeat (frag_len)
                    send_byte(byte_t'($urandom));
            end
            send_frame(random_frame($urandom_range(0, 7) == 0));
        end
        source_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        byte_bus.valid   <= 1'b0;
        byte_bus.rx_byte <= ZERO_BYTE;
        frame_pos = CNT_IDLE;
        for (int i = 0; i < FRAME_LEN; i++)
            frame_buf[i] = ZERO_BYTE;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hunting();
        test_channel_extremes();
        test_sync_inside_frame();
        test_output_stall();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_frames.size() != 0)
        begin
            $display("%t: %0d frames never came out", $realtime, expected_frames.size());
            errors++;
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sbfd_pkg.sv
rtl/core/sbfd_if.sv
rtl/core/sbfd_cell.sv
rtl/core/sbus_frame_channel_decoder.sv
rtl/core/sbfd_checker.sv
sim/sbus_frame_channel_decoder_test.sv
